@@ src/srtl_pkg.sv @@
`timescale 1ns / 1ps

package srtl_pkg;

   localparam int MAX_OBJECTS = 64;
   localparam int MAX_SYMBOLS = 4096;

   // Symbol size that stands in for a loaded size of zero
   localparam logic [63:0] ZERO_SIZE_SYMBOL = 64'd16;

   localparam int OBJ_AW    = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int SYM_AW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int OBJ_CNT_W = $clog2(MAX_OBJECTS + 1);
   localparam int SYM_CNT_W = $clog2(MAX_SYMBOLS + 1);
   // Search position / range: wide enough for either table
   localparam int POS_W     = (SYM_CNT_W > OBJ_CNT_W) ? SYM_CNT_W : OBJ_CNT_W;

   // Fixed field widths
   localparam int CMD_W       = 2;
   localparam int SLOT_W      = 12;
   localparam int ADDR_W      = 64;
   localparam int FIRST_W     = 12;
   localparam int TOTAL_W     = 13;
   localparam int COUNT_CSR_W = 7;
   localparam int OBJ_IDX_W   = 6;
   localparam int SYM_IDX_W   = 12;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_OBJ = 2'd0,
      CMD_LOAD_SYM = 2'd1,
      CMD_LOOKUP   = 2'd2,
      CMD_UNUSED   = 2'd3
   } srtl_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OBJ_START,
      ST_OBJ_SEARCH,
      ST_OBJ_CHECK,
      ST_SYM_START,
      ST_SYM_SEARCH,
      ST_SYM_CHECK,
      ST_RESP
   } srtl_state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [ADDR_W-1:0]  size;
      logic [FIRST_W-1:0] first;
      logic [TOTAL_W-1:0] total;
   } obj_entry_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] size;
   } sym_entry_type;

endpackage

@@ src/srtl_req_if.sv @@
`timescale 1ns / 1ps

interface srtl_req_if
   import srtl_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [SLOT_W-1:0]   entry_index;
   logic [ADDR_W-1:0]   entry_base;
   logic [ADDR_W-1:0]   entry_length;
   logic [FIRST_W-1:0]  first_symbol;
   logic [TOTAL_W-1:0]  symbol_total;
   logic [ADDR_W-1:0]   query_address;

   modport source (
      output valid, cmd, entry_index, entry_base, entry_length,
             first_symbol, symbol_total, query_address,
      input  ready
   );

   modport sink (
      input  valid, cmd, entry_index, entry_base, entry_length,
             first_symbol, symbol_total, query_address,
      output ready
   );
endinterface

@@ src/srtl_rsp_if.sv @@
`timescale 1ns / 1ps

interface srtl_rsp_if
   import srtl_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  object_found;
   logic [OBJ_IDX_W-1:0]  object_index;
   logic                  symbol_found;
   logic [SYM_IDX_W-1:0]  symbol_index;
   logic [ADDR_W-1:0]     offset;

   modport source (
      output valid, object_found, object_index, symbol_found, symbol_index, offset,
      input  ready
   );

   modport sink (
      input  valid, object_found, object_index, symbol_found, symbol_index, offset,
      output ready
   );
endinterface

@@ src/sorted_range_table_lookup.sv @@
`timescale 1ns / 1ps

// Two-level address resolver over a sorted object table and a flat symbol table.
// req_ch (valid/ready) carries commands: load object entry, load symbol entry,
//   or look up an address. rsp_ch carries one result transfer per lookup only.
// csr_wr_en/csr_wr_data write object_count; write it only while the block is idle.
// Loads: the entry is written at the accepting edge, and ready stays up.
// A lookup runs one table probe per cycle through a single shared compare and
//   subtract unit; each probe reads a registered-output RAM. rsp_ch.valid rises
//   when the object search and, after an object hit, the symbol search are done;
//   misses finish earlier. Each search is a sequential binary search with one
//   RAM read per probe.
// req_ch.ready is low from acceptance of a lookup until its result is taken,
//   so a new item is accepted the cycle after the rsp transfer.
// If the receiver stalls, the result is held steady in registers until rsp_ch.ready.
// Reset (synchronous, active high) clears object_count and the sequencer; the
//   table RAMs are not cleared and hold nothing meaningful until loaded.
// Entries must be loaded in ascending order of base.

module sorted_range_table_lookup
   import srtl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   srtl_req_if.sink               req_ch,
   srtl_rsp_if.source             rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [COUNT_CSR_W-1:0] csr_wr_data
);

   // Sequencer and working registers
   srtl_state_type         state_ff, state_in;
   logic [COUNT_CSR_W-1:0] object_count_ff;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [POS_W-1:0]       range_ff, range_in;

   // Result registers
   logic                   obj_found_ff, obj_found_in;
   logic [OBJ_IDX_W-1:0]   obj_idx_ff, obj_idx_in;
   logic                   sym_found_ff, sym_found_in;
   logic [SYM_IDX_W-1:0]   sym_idx_ff, sym_idx_in;
   logic [ADDR_W-1:0]      offset_ff, offset_in;

   // RAM ports
   logic                   obj_wr_en, sym_wr_en;
   obj_entry_type          obj_wr_data, obj_rd_data;
   sym_entry_type          sym_wr_data, sym_rd_data;
   logic [POS_W-1:0]       probe_addr;

   // Shared probe unit signals
   logic                   obj_phase;
   logic [ADDR_W-1:0]      probe_base, probe_size, probe_rel;
   logic                   base_le_addr, rel_in_range;
   logic [POS_W-1:0]       half, step_pos, step_range;
   logic [POS_W-1:0]       iss_pos, iss_range;
   logic [POS_W-1:0]       obj_count_clamped, slice_cnt;
   logic                   req_fire;

   assign req_fire = req_ch.valid && req_ch.ready;

   // ---------------- table stores ----------------
   always_comb begin
      obj_wr_en = req_fire && (req_ch.cmd == CMD_LOAD_OBJ)
                  && (int'(req_ch.entry_index) < MAX_OBJECTS);
      sym_wr_en = req_fire && (req_ch.cmd == CMD_LOAD_SYM)
                  && (int'(req_ch.entry_index) < MAX_SYMBOLS);

      obj_wr_data.base  = req_ch.entry_base;
      obj_wr_data.size  = req_ch.entry_length;
      obj_wr_data.first = req_ch.first_symbol;
      obj_wr_data.total = req_ch.symbol_total;

      sym_wr_data.base  = req_ch.entry_base;
      // zero-length symbols get a nominal size
      sym_wr_data.size  = (req_ch.entry_length == '0) ? ZERO_SIZE_SYMBOL
                                                      : req_ch.entry_length;
   end

   srtl_ram #(
      .WIDTH ($bits(obj_entry_type)),
      .DEPTH (MAX_OBJECTS)
   ) u_obj_ram (
      .clock   (clock),
      .wr_en   (obj_wr_en),
      .wr_addr (OBJ_AW'(req_ch.entry_index)),
      .wr_data (obj_wr_data),
      .rd_addr (OBJ_AW'(probe_addr)),
      .rd_data (obj_rd_data)
   );

   srtl_ram #(
      .WIDTH ($bits(sym_entry_type)),
      .DEPTH (MAX_SYMBOLS)
   ) u_sym_ram (
      .clock   (clock),
      .wr_en   (sym_wr_en),
      .wr_addr (SYM_AW'(req_ch.entry_index)),
      .wr_data (sym_wr_data),
      .rd_addr (SYM_AW'(probe_addr)),
      .rd_data (sym_rd_data)
   );

   // ---------------- shared compare / subtract unit ----------------
   always_comb begin
      obj_phase    = (state_ff == ST_OBJ_SEARCH) || (state_ff == ST_OBJ_CHECK);
      probe_base   = obj_phase ? obj_rd_data.base : sym_rd_data.base;
      probe_size   = obj_phase ? obj_rd_data.size : sym_rd_data.size;
      base_le_addr = (probe_base <= addr_ff);
      probe_rel    = addr_ff - probe_base;        // wraps mod 2^64
      rel_in_range = (probe_rel <= probe_size);

      // one halving step of the search
      half       = range_ff >> 1;
      step_pos   = base_le_addr ? pos_ff + half : pos_ff;
      step_range = base_le_addr ? range_ff - half : half;
   end

   // clamp of the configured count and of the object's symbol slice
   always_comb begin
      if (int'(object_count_ff) > MAX_OBJECTS) begin
         obj_count_clamped = POS_W'(MAX_OBJECTS);
      end else begin
         obj_count_clamped = POS_W'(object_count_ff);
      end

      if (int'(obj_rd_data.first) >= MAX_SYMBOLS) begin
         slice_cnt = '0;
      end else if (int'(obj_rd_data.total) > MAX_SYMBOLS - int'(obj_rd_data.first)) begin
         slice_cnt = POS_W'(MAX_SYMBOLS - int'(obj_rd_data.first));
      end else begin
         slice_cnt = POS_W'(obj_rd_data.total);
      end
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         object_count_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            object_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      pos_ff       <= pos_in;
      range_ff     <= range_in;
      obj_found_ff <= obj_found_in;
      obj_idx_ff   <= obj_idx_in;
      sym_found_ff <= sym_found_in;
      sym_idx_ff   <= sym_idx_in;
      offset_ff    <= offset_in;
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      pos_in       = pos_ff;
      range_in     = range_ff;
      obj_found_in = obj_found_ff;
      obj_idx_in   = obj_idx_ff;
      sym_found_in = sym_found_ff;
      sym_idx_in   = sym_idx_ff;
      offset_in    = offset_ff;
      iss_pos      = pos_ff;
      iss_range    = range_ff;
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid && (req_ch.cmd == CMD_LOOKUP)) begin
               addr_in      = req_ch.query_address;
               obj_found_in = 1'b0;
               obj_idx_in   = '0;
               sym_found_in = 1'b0;
               sym_idx_in   = '0;
               offset_in    = req_ch.query_address;
               pos_in       = '0;
               range_in     = obj_count_clamped;
               state_in     = (obj_count_clamped == '0) ? ST_RESP : ST_OBJ_START;
            end
         end

         ST_OBJ_START: begin
            state_in = (range_ff > POS_W'(1)) ? ST_OBJ_SEARCH : ST_OBJ_CHECK;
         end

         ST_OBJ_SEARCH: begin
            iss_pos   = step_pos;
            iss_range = step_range;
            pos_in    = step_pos;
            range_in  = step_range;
            state_in  = (step_range > POS_W'(1)) ? ST_OBJ_SEARCH : ST_OBJ_CHECK;
         end

         ST_OBJ_CHECK: begin
            // the probe read this cycle is the candidate object itself
            if (rel_in_range) begin
               obj_found_in = 1'b1;
               obj_idx_in   = OBJ_IDX_W'(pos_ff);
               offset_in    = probe_rel;
               pos_in       = POS_W'(obj_rd_data.first);
               range_in     = slice_cnt;
               state_in     = (slice_cnt == '0) ? ST_RESP : ST_SYM_START;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_SYM_START: begin
            state_in = (range_ff > POS_W'(1)) ? ST_SYM_SEARCH : ST_SYM_CHECK;
         end

         ST_SYM_SEARCH: begin
            iss_pos   = step_pos;
            iss_range = step_range;
            pos_in    = step_pos;
            range_in  = step_range;
            state_in  = (step_range > POS_W'(1)) ? ST_SYM_SEARCH : ST_SYM_CHECK;
         end

         ST_SYM_CHECK: begin
            if (rel_in_range) begin
               sym_found_in = 1'b1;
               sym_idx_in   = SYM_IDX_W'(pos_ff);
               offset_in    = probe_rel;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            rsp_ch.valid = 1'b1;
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next probe: the midpoint while more than one candidate is left,
      // else the final candidate itself
      probe_addr = (iss_range > POS_W'(1)) ? iss_pos + (iss_range >> 1) : iss_pos;
   end

   assign rsp_ch.object_found = obj_found_ff;
   assign rsp_ch.object_index = obj_idx_ff;
   assign rsp_ch.symbol_found = sym_found_ff;
   assign rsp_ch.symbol_index = sym_idx_ff;
   assign rsp_ch.offset       = offset_ff;

endmodule

@@ src/srtl_ram.sv @@
`timescale 1ns / 1ps

module srtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ dv/tb_sorted_range_table_lookup.sv @@
`timescale 1ns / 1ps

// Drives load and lookup commands into sorted_range_table_lookup, keeps its own copy of
// both tables and the object count, and checks every result transfer in order.
module tb_sorted_range_table_lookup;
   import srtl_pkg::*;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int ITEM_BUDGET   = 1300;
   // loads and unused commands give nothing to wait on
   localparam int SETTLE_CYCLES = 30;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int COUNT_MAX     = (1 << COUNT_CSR_W) - 1;
   localparam logic [ADDR_W-1:0] ALL_ONES = '1;

   // One command as presented on the request channel
   typedef struct {
      srtl_cmd_type         op;
      logic [SLOT_W-1:0]    slot;
      logic [ADDR_W-1:0]    base;
      logic [ADDR_W-1:0]    length;
      logic [FIRST_W-1:0]   lo;
      logic [TOTAL_W-1:0]   total;
      logic [ADDR_W-1:0]    addr;
   } command_type;

   // What a lookup should resolve to
   typedef struct packed {
      logic                  obj_hit;
      logic [OBJ_IDX_W-1:0]  obj_idx;
      logic                  sym_hit;
      logic [SYM_IDX_W-1:0]  sym_idx;
      logic [ADDR_W-1:0]     offset;
   } resolution_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [COUNT_CSR_W-1:0] csr_wr_data;

   srtl_req_if req_bus ();
   srtl_rsp_if rsp_bus ();

   sorted_range_table_lookup dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow tables, updated at the accepting edge of each load
   logic [ADDR_W-1:0]      obj_base_m  [MAX_OBJECTS];
   logic [ADDR_W-1:0]      obj_size_m  [MAX_OBJECTS];
   logic [FIRST_W-1:0]     obj_first_m [MAX_OBJECTS];
   logic [TOTAL_W-1:0]     obj_total_m [MAX_OBJECTS];
   logic [ADDR_W-1:0]      sym_base_m  [MAX_SYMBOLS];
   logic [ADDR_W-1:0]      sym_size_m  [MAX_SYMBOLS];
   logic [COUNT_CSR_W-1:0] obj_count_m;

   // Resolutions still owed by the block, oldest first
   resolution_type pending_resolutions [$];

   int unsigned work_items;
   int unsigned ignored_items;
   int unsigned lookups_sent;
   int unsigned object_hits;
   int unsigned symbol_hits;
   int unsigned count_writes;
   int unsigned mismatches;
   bit          req_calm;
   bit          rsp_calm;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------------------------

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Idle length: mostly none or short, now and then a long one; nothing while calm
   function automatic int unsigned gap_len(bit calm);
      int unsigned p;
      if (calm) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Sizes scaled to the table spacing, with zero and the full range mixed in
   function automatic logic [ADDR_W-1:0] rand_size(logic [ADDR_W-1:0] step);
      case ($urandom_range(0, 9))
         0, 1:       return '0;
         2, 3, 4, 5: return rand64() % step;
         6, 7:       return step + rand64() % step;
         8:          return ALL_ONES;
         default:    return rand64();
      endcase
   endfunction

   // Every field random, so unused fields toggle too
   function automatic command_type random_command(srtl_cmd_type op);
      command_type c;
      c.op     = op;
      c.slot   = SLOT_W'($urandom_range(0, 4095));
      c.base   = rand64();
      c.length = rand64();
      c.lo     = FIRST_W'($urandom_range(0, MAX_SYMBOLS - 1));
      c.total  = TOTAL_W'($urandom_range(0, MAX_SYMBOLS));
      c.addr   = rand64();
      return c;
   endfunction

   function automatic command_type cmd_of(srtl_cmd_type op, int unsigned slot,
                                       logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] length,
                                       int unsigned lo, int unsigned total,
                                       logic [ADDR_W-1:0] addr);
      command_type c;
      c.op     = op;
      c.slot   = SLOT_W'(slot);
      c.base   = base;
      c.length = length;
      c.lo     = FIRST_W'(lo);
      c.total  = TOTAL_W'(total);
      c.addr   = addr;
      return c;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Symbols an object really owns: its count cut at the end of the symbol table
   function automatic int unsigned slice_len(int unsigned o);
      int unsigned lo, n;
      lo = obj_first_m[o];
      n  = obj_total_m[o];
      if (lo >= MAX_SYMBOLS) return 0;
      if (n > MAX_SYMBOLS - lo) n = MAX_SYMBOLS - lo;
      return n;
   endfunction

   // Halving search for the last base at or below addr in [start, start+len)
   function automatic int unsigned last_at_or_below(bit in_symbols, int unsigned start,
                                                    int unsigned len, logic [ADDR_W-1:0] addr);
      int unsigned pos, span, half;
      logic [ADDR_W-1:0] probe;
      pos  = start;
      span = len;
      while (span > 1) begin
         half  = span / 2;
         probe = in_symbols ? sym_base_m[pos + half] : obj_base_m[pos + half];
         if (probe <= addr) begin
            pos  += half;
            span -= half;
         end else begin
            span = half;
         end
      end
      return pos;
   endfunction

   function automatic resolution_type resolve_address(logic [ADDR_W-1:0] addr);
      resolution_type r;
      int unsigned cnt, o, s, n;
      logic [ADDR_W-1:0] rel;
      r        = '0;
      r.offset = addr;
      cnt      = obj_count_m;
      if (cnt > MAX_OBJECTS) cnt = MAX_OBJECTS;
      if (cnt > 0) begin
         o   = last_at_or_below(1'b0, 0, cnt, addr);
         rel = addr - obj_base_m[o];      // wraps mod 2^64 below the first base
         if (rel <= obj_size_m[o]) begin
            r.obj_hit = 1'b1;
            r.obj_idx = OBJ_IDX_W'(o);
            r.offset  = rel;
            n = slice_len(o);
            if (n > 0) begin
               s   = last_at_or_below(1'b1, obj_first_m[o], n, addr);
               rel = addr - sym_base_m[s];
               if (rel <= sym_size_m[s]) begin
                  r.sym_hit = 1'b1;
                  r.sym_idx = SYM_IDX_W'(s);
                  r.offset  = rel;
               end
            end
         end
      end
      return r;
   endfunction

   // Effect of one accepted command on the shadow tables and the owed results
   function automatic void apply_command(command_type c);
      resolution_type r;
      case (c.op)
         CMD_LOAD_OBJ: begin
            if (c.slot < MAX_OBJECTS) begin
               obj_base_m[c.slot]  = c.base;
               obj_size_m[c.slot]  = c.length;   // zero object size stays zero
               obj_first_m[c.slot] = c.lo;
               obj_total_m[c.slot] = c.total;
               work_items++;
            end else begin
               ignored_items++;
            end
         end
         CMD_LOAD_SYM: begin
            if (c.slot < MAX_SYMBOLS) begin
               sym_base_m[c.slot] = c.base;
               sym_size_m[c.slot] = (c.length == '0) ? ZERO_SIZE_SYMBOL : c.length;
               work_items++;
            end else begin
               ignored_items++;
            end
         end
         CMD_LOOKUP: begin
            r = resolve_address(c.addr);
            pending_resolutions.push_back(r);
            work_items++;
            lookups_sent++;
            object_hits += r.obj_hit;
            symbol_hits += r.sym_hit;
         end
         default: ignored_items++;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   // Present one command after a random idle, hold it until the transfer. valid is left
   // high so a back-to-back command keeps it up without a drop in the same step.
   task automatic send_item(input command_type c);
      int unsigned idle;
      idle = gap_len(req_calm);
      if (idle > 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= c.op;
      req_bus.entry_index   <= c.slot;
      req_bus.entry_base    <= c.base;
      req_bus.entry_length  <= c.length;
      req_bus.first_symbol  <= c.lo;
      req_bus.symbol_total  <= c.total;
      req_bus.query_address <= c.addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_command(c);
   endtask

   // Commands the block must drop: the spare opcode or an object slot past the table
   task automatic send_noise();
      command_type c;
      if ($urandom_range(0, 1) == 0) begin
         c = random_command(CMD_UNUSED);
      end else begin
         c      = random_command(CMD_LOAD_OBJ);
         c.slot = SLOT_W'($urandom_range(MAX_OBJECTS, 4095));
      end
      send_item(c);
   endtask

   // The count is only changed once the block has gone quiet
   task automatic write_object_count(input logic [COUNT_CSR_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (pending_resolutions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      obj_count_m  = value;
      count_writes++;
   endtask

   // Fresh sorted table of n_obj objects (n_obj >= 1), each with a sorted symbol slice.
   // Slices sit in the low part of the symbol table; at most one object reaches the top
   // end so that its count gets cut.
   task automatic load_random_table(input int unsigned n_obj);
      logic [ADDR_W-1:0] step, span, cur, sym_step, sb;
      int unsigned cursor, tail_obj, k, j, nsym, sym_lo;
      command_type c;
      case ($urandom_range(0, 4))
         0:       step = 64'd16;
         1:       step = 64'd1 << 12;
         2:       step = 64'd1 << 20;
         3:       step = 64'd1 << 32;
         default: step = 64'd1 << 48;
      endcase
      sym_step = step >> 3;
      span     = (n_obj + 4) * step;
      cur      = ($urandom_range(0, 9) == 0) ? '0 : rand64();
      if (cur > ~span) cur = ~span;     // keep the whole table clear of wrap-around
      cursor   = $urandom_range(0, 2048);
      tail_obj = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_obj - 1) : n_obj;
      for (k = 0; k < n_obj; k++) begin
         if (k > 0) cur += 1 + rand64() % step;
         c        = random_command(CMD_LOAD_OBJ);
         c.slot   = SLOT_W'(k);
         c.base   = cur;
         c.length = rand_size(step);
         if (k == tail_obj) begin
            nsym   = $urandom_range(1, 8);
            sym_lo = MAX_SYMBOLS - nsym;
            c.lo   = FIRST_W'(sym_lo);
            case ($urandom_range(0, 2))
               0:       c.total = TOTAL_W'(MAX_SYMBOLS);
               1:       c.total = TOTAL_W'(MAX_SYMBOLS - 1);
               default: c.total = TOTAL_W'(nsym + $urandom_range(0, 300));
            endcase
         end else begin
            nsym = ($urandom_range(0, 5) == 0) ? 0 :
                   $urandom_range(1, ($urandom_range(0, 4) == 0) ? 16 : 6);
            sym_lo = cursor;
            if (nsym == 0) begin
               c.total = '0;                // empty slice, first slot is don't-care
            end else begin
               c.lo    = FIRST_W'(cursor);
               c.total = TOTAL_W'(nsym);
               cursor += nsym;
            end
         end
         if ($urandom_range(0, 19) == 0) send_noise();
         send_item(c);
         sb = cur + rand64() % sym_step;
         for (j = 0; j < nsym; j++) begin
            c        = random_command(CMD_LOAD_SYM);
            c.slot   = SLOT_W'(sym_lo + j);
            c.base   = sb;
            c.length = rand_size(sym_step);
            send_item(c);
            sb += 1 + rand64() % sym_step;
         end
      end
   endtask

   // Addresses around object and symbol edges, with wild ones mixed in
   function automatic logic [ADDR_W-1:0] pick_address(int unsigned n_obj);
      int unsigned o, s, n;
      logic [ADDR_W-1:0] b, sz;
      if (n_obj == 0 || $urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0:       return '0;
            1:       return ALL_ONES;
            default: return rand64();
         endcase
      end
      o  = $urandom_range(0, n_obj - 1);
      b  = obj_base_m[o];
      sz = obj_size_m[o];
      n  = slice_len(o);
      if (n > 0 && $urandom_range(0, 1) == 0) begin
         s  = obj_first_m[o] + $urandom_range(0, n - 1);
         b  = sym_base_m[s];
         sz = sym_size_m[s];
      end
      case ($urandom_range(0, 5))
         0:       return b;
         1:       return b + sz;
         2:       return b + sz + 1;
         3:       return b - 1;
         4:       return b + ((sz == ALL_ONES) ? rand64() : rand64() % (sz + 1));
         default: return b + $urandom_range(0, 64);
      endcase
   endfunction

   // Mostly lookups; now and then an entry is reloaded in place (same base, so the
   // order holds) or a command that must be dropped slips in
   task automatic run_lookups(input int unsigned n_obj, input int unsigned n_look);
      int unsigned i, o, n;
      command_type c;
      for (i = 0; i < n_look; i++) begin
         case ($urandom_range(0, 19))
            0: send_noise();
            1: begin
               if (n_obj > 0) begin
                  o        = $urandom_range(0, n_obj - 1);
                  c        = random_command(CMD_LOAD_OBJ);
                  c.slot   = SLOT_W'(o);
                  c.base   = obj_base_m[o];
                  c.length = rand_size(64'd1 << $urandom_range(4, 48));
                  c.lo     = obj_first_m[o];
                  c.total  = obj_total_m[o];
                  send_item(c);
               end
            end
            2: begin
               if (n_obj > 0) begin
                  o = $urandom_range(0, n_obj - 1);
                  n = slice_len(o);
                  if (n > 0) begin
                     c        = random_command(CMD_LOAD_SYM);
                     c.slot   = SLOT_W'(obj_first_m[o] + $urandom_range(0, n - 1));
                     c.base   = sym_base_m[c.slot];
                     c.length = rand_size(64'd1 << $urandom_range(4, 40));
                     send_item(c);
                  end
               end
            end
            default: begin
               c      = random_command(CMD_LOOKUP);
               c.addr = pick_address(n_obj);
               send_item(c);
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Hand-built two-object table: empty table, dropped commands, zero object size,
   // zero symbol size, a slice cut at the top of the symbol table, wrap-around offsets
   task automatic test_directed_corners;
      int unsigned k;
      logic [ADDR_W-1:0] dir_base [6] = '{64'h1000, 64'h1010, 64'h1020, 64'h1030, 64'h1040,
                                         64'hFFFF_FFFF_FFFF_FFF0};
      logic [ADDR_W-1:0] dir_len  [6] = '{64'd0, 64'd4, 64'd0, 64'hF, 64'd0, 64'd0};
      logic [ADDR_W-1:0] dir_addr [9] = '{64'h0, 64'h1, 64'h1000, 64'h1014, 64'h1015,
                                         64'h103F, 64'h1050, 64'h1051, ALL_ONES};
      write_object_count('0);
      send_item(cmd_of(CMD_LOOKUP, 0, '0, '0, 0, 0, ALL_ONES));
      send_item(cmd_of(CMD_UNUSED, 4095, ALL_ONES, ALL_ONES, 4095, 4096, ALL_ONES));
      send_item(cmd_of(CMD_LOAD_OBJ, 4095, ALL_ONES, ALL_ONES, 4095, 4096, ALL_ONES));
      send_item(cmd_of(CMD_LOAD_OBJ, 0, '0, '0, 0, 0, '0));
      send_item(cmd_of(CMD_LOAD_OBJ, 1, 64'h1000, ALL_ONES, 4090, 4096, '0));
      for (k = 0; k < 6; k++)
         send_item(cmd_of(CMD_LOAD_SYM, 4090 + k, dir_base[k], dir_len[k], 0, 0, '0));
      write_object_count(COUNT_CSR_W'(2));
      for (k = 0; k < 9; k++)
         send_item(cmd_of(CMD_LOOKUP, 0, '0, '0, 0, 0, dir_addr[k]));
      // shrink a symbol and an object in place
      send_item(cmd_of(CMD_LOAD_SYM, 4094, 64'h1040, 64'd1, 0, 0, '0));
      send_item(cmd_of(CMD_LOOKUP, 0, '0, '0, 0, 0, 64'h1042));
      send_item(cmd_of(CMD_LOAD_OBJ, 1, 64'h1000, 64'h100, 4095, 4095, '0));
      send_item(cmd_of(CMD_LOOKUP, 0, '0, '0, 0, 0, ALL_ONES));
      send_item(cmd_of(CMD_LOOKUP, 0, '0, '0, 0, 0, 64'h10FF));
   endtask

   // Full object table, count above the table size and then exactly at it
   task automatic test_count_saturation;
      load_random_table(MAX_OBJECTS);
      write_object_count(COUNT_CSR_W'(COUNT_MAX));
      run_lookups(MAX_OBJECTS, 20);
      write_object_count(COUNT_CSR_W'(MAX_OBJECTS));
      run_lookups(MAX_OBJECTS, 20);
   endtask

   // Phases of: new table, new count, a burst of lookups
   task automatic test_random_tables;
      int unsigned n_obj, count, p;
      while (work_items < ITEM_BUDGET) begin
         req_calm = ($urandom_range(0, 3) == 0);
         p = $urandom_range(0, 19);
         if (p == 0)     n_obj = 0;
         else if (p == 1) n_obj = MAX_OBJECTS;
         else if (p < 5)  n_obj = $urandom_range(9, MAX_OBJECTS - 1);
         else             n_obj = $urandom_range(1, 8);
         count = n_obj;
         if (n_obj == MAX_OBJECTS && $urandom_range(0, 1) == 1)
            count = $urandom_range(MAX_OBJECTS + 1, COUNT_MAX);
         if (n_obj > 0) load_random_table(n_obj);
         write_object_count(COUNT_CSR_W'(count));
         run_lookups(n_obj, $urandom_range(15, 40));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side: random back-pressure and in-order check of every transfer
   // ---------------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] want,
                                  input logic [ADDR_W-1:0] got);
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
      mismatches++;
   endtask

   initial begin : result_checker
      resolution_type want;
      int unsigned hold, seen;
      rsp_bus.ready = 1'b0;
      hold = 0;
      seen = 0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen++;
            if (seen % 50 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
            if (pending_resolutions.size() == 0) begin
               $display("%0t: result transfer with no lookup outstanding (offset %h)",
                        $time, rsp_bus.offset);
               mismatches++;
            end else begin
               want = pending_resolutions.pop_front();
               if (rsp_bus.object_found !== want.obj_hit)
                  report_mismatch("object_found", want.obj_hit, rsp_bus.object_found);
               if (rsp_bus.object_index !== want.obj_idx)
                  report_mismatch("object_index", want.obj_idx, rsp_bus.object_index);
               if (rsp_bus.symbol_found !== want.sym_hit)
                  report_mismatch("symbol_found", want.sym_hit, rsp_bus.symbol_found);
               if (rsp_bus.symbol_index !== want.sym_idx)
                  report_mismatch("symbol_index", want.sym_idx, rsp_bus.symbol_index);
               if (rsp_bus.offset !== want.offset)
                  report_mismatch("offset", want.offset, rsp_bus.offset);
            end
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            hold = gap_len(rsp_calm);
            rsp_bus.ready <= (hold == 0);
         end
      end
   end

   // Watchdog on total run length
   initial begin : cycle_watchdog
      int unsigned cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run stalled, %0d results still owed", $time,
                     pending_resolutions.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = CMD_UNUSED;
      req_bus.entry_index   = '0;
      req_bus.entry_base    = '0;
      req_bus.entry_length  = '0;
      req_bus.first_symbol  = '0;
      req_bus.symbol_total  = '0;
      req_bus.query_address = '0;
      obj_count_m           = '0;
      work_items    = 0;
      ignored_items = 0;
      lookups_sent  = 0;
      object_hits   = 0;
      symbol_hits   = 0;
      count_writes  = 0;
      mismatches    = 0;
      req_calm      = 1'b0;
      rsp_calm      = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      test_count_saturation();
      test_random_tables();

      // let the last lookups come home, then allow the pipeline to settle
      req_bus.valid <= 1'b0;
      while (pending_resolutions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Applied %0d commands (%0d lookups, %0d object hits, %0d symbol hits)",
               work_items, lookups_sent, object_hits, symbol_hits);
      $display("Dropped %0d spare or out-of-range commands; object count set %0d times",
               ignored_items, count_writes);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/srtl_pkg.sv
src/srtl_req_if.sv
src/srtl_rsp_if.sv
src/srtl_ram.sv
src/sorted_range_table_lookup.sv
dv/tb_sorted_range_table_lookup.sv
